### sv/hvc_pkg.sv
// Shared types and constants for the heightmap terrain voxel classifier.
// Holds the configuration and result structs, the sampler state type and
// the divider request and response structs. Depends on nothing.
`timescale 1ns / 1ps

package hvc_pkg;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [2:0] CFG_MAP_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_MAP_DEPTH     = 3'd1;
  localparam logic [2:0] CFG_PIXEL_MIN     = 3'd2;
  localparam logic [2:0] CFG_PIXEL_MAX     = 3'd3;
  localparam logic [2:0] CFG_HEIGHT_SCALE  = 3'd4;
  localparam logic [2:0] CFG_COLUMN_HEIGHT = 3'd5;

  localparam logic [1:0] KIND_AIR   = 2'd0;
  localparam logic [1:0] KIND_GRASS = 2'd1;
  localparam logic [1:0] KIND_DIRT  = 2'd2;
  localparam logic [1:0] KIND_STONE = 2'd3;

  localparam int DIV_W      = 34;
  localparam int DIV_STEP_W = 6;
  localparam int HW         = 34;

  localparam logic [DIV_STEP_W-1:0] WRAP_STEPS = 6'd16;
  localparam logic [DIV_STEP_W-1:0] NORM_STEPS = 6'd34;

  typedef struct packed {
    logic [8:0]  map_width;
    logic [8:0]  map_depth;
    logic [7:0]  pixel_min;
    logic [7:0]  pixel_max;
    logic [15:0] height_scale;
    logic [8:0]  column_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    map_width:     9'd0,
    map_depth:     9'd0,
    pixel_min:     8'd0,
    pixel_max:     8'd255,
    height_scale:  16'd16384,
    column_height: 9'd96
  };

  typedef struct packed {
    logic [1:0]  block_kind;
    logic [15:0] surface_height;
  } res_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_W-1:0]      num;
    logic [8:0]            den;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [8:0]       rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SM1, S_SM2, S_WX, S_WXW, S_WZ, S_WZW, S_RD,
    S_PIX, S_DIV, S_DIVW, S_ML, S_MH, S_MS, S_FIN, S_OUT
  } smp_state_t;

  // Highest allowed height in whole voxels: column height less one, with
  // zero treated as one and anything above 256 treated as 256.
  function automatic logic [7:0] col_limit(input logic [8:0] ch);
    logic [7:0] lim;
    if (ch == 9'd0) begin
      lim = 8'd0;
    end else if (ch > 9'd256) begin
      lim = 8'd255;
    end else begin
      lim = 8'(ch - 9'd1);
    end
    return lim;
  endfunction

endpackage

### sv/hvc_pixel_mem.sv
// Heightmap pixel store: one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module hvc_pixel_mem #(
  parameter int MAP_COLS_MAX = 256,
  parameter int MAP_ROWS_MAX = 256,
  localparam int DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/hvc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, used for the
// coordinate wrap and the pixel normalisation. Depends on hvc_pkg.
`timescale 1ns / 1ps

module hvc_divider import hvc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, done_r;
  logic [DIV_STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]      num_r, quo_r;
  logic [8:0]            rem_r;
  logic [9:0]            trial;
  logic                  fits;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? 9'(trial - {1'b0, req.den}) : trial[8:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### sv/hvc_sampler.sv
// Sample sequencer: wraps the coordinates, reads and normalises the four
// neighbour pixels, blends them and classifies the voxel.
// Depends on hvc_pkg; drives hvc_pixel_mem reads and hvc_divider.
`timescale 1ns / 1ps

module hvc_sampler import hvc_pkg::*; #(
  parameter int MAP_COLS_MAX = 256,
  parameter int MAP_ROWS_MAX = 256,
  localparam int ADDR_W = $clog2(MAP_COLS_MAX * MAP_ROWS_MAX)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                start,
  input  logic signed [23:0]  sample_x,
  input  logic signed [23:0]  sample_z,
  input  logic signed [15:0]  sample_y,
  output logic                idle,
  output logic                res_valid,
  output res_t                res,
  input  logic                res_take,
  output logic                mem_re,
  output logic [ADDR_W-1:0]   mem_raddr,
  input  logic [7:0]          mem_rdata,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp
);

  localparam logic [12:0] COLS_L = 13'(MAP_COLS_MAX);
  localparam logic [12:0] ROWS_L = 13'(MAP_ROWS_MAX);

  smp_state_t state_r, state_nxt;

  logic signed [15:0] xi_r, zi_r, y_r;
  logic [7:0]         fx_r, fz_r;
  logic [15:0]        sqx_r, sqz_r;
  logic [23:0]        sx_r, sz_r;
  logic [8:0]         x0_r, x1_r, z0_r, z1_r;
  logic [1:0]         k_r, bsel_r;
  logic signed [25:0] p_r;
  logic signed [HW-1:0] h_r [4];
  logic signed [HW-1:0] a_r, b_r, hf_r;
  logic signed [43:0] plo_r, phi_r;
  res_t               res_r;

  logic [8:0]  w_eff, d_eff;
  logic        no_map, rng_ok;
  logic [7:0]  rng8;
  logic [15:0] xabs, zabs;
  logic        wneg;
  logic [8:0]  wmod, wrap, wrap_nx;
  logic [9:0]  wrap_inc;
  logic [9:0]  tx, tz;
  logic signed [8:0]  dpix;
  logic signed [25:0] pval;
  logic signed [35:0] nval;
  logic [35:0]        nabs;
  logic signed [HW-1:0] hpix;
  logic signed [34:0] diff;
  logic signed [HW-1:0] base;
  logic [23:0]        wt;
  logic signed [18:0] mop;
  logic signed [43:0] prod;
  logic signed [61:0] full, rnd;
  logic signed [HW-1:0] val;
  logic [7:0]         lim;
  logic signed [HW-1:0] hmax;
  logic [23:0]        hc;
  logic [15:0]        hq;
  logic signed [25:0] ys, hy;
  logic [1:0]         kind;
  logic [8:0]         rd_col, rd_row;

  assign w_eff  = ({4'b0, cfg.map_width} > COLS_L) ? 9'(MAP_COLS_MAX) : cfg.map_width;
  assign d_eff  = ({4'b0, cfg.map_depth} > ROWS_L) ? 9'(MAP_ROWS_MAX) : cfg.map_depth;
  assign no_map = (w_eff == 9'd0) || (d_eff == 9'd0);
  assign rng_ok = cfg.pixel_max > cfg.pixel_min;
  assign rng8   = cfg.pixel_max - cfg.pixel_min;

  assign xabs = xi_r[15] ? (~xi_r + 16'd1) : xi_r;
  assign zabs = zi_r[15] ? (~zi_r + 16'd1) : zi_r;

  // Floor modulo: a negative coordinate with a non-zero remainder folds back.
  assign wneg     = (state_r == S_WXW) ? xi_r[15] : zi_r[15];
  assign wmod     = (state_r == S_WXW) ? w_eff : d_eff;
  assign wrap     = (wneg && div_rsp.rem != 9'd0) ? wmod - div_rsp.rem : div_rsp.rem;
  assign wrap_inc = {1'b0, wrap} + 10'd1;
  assign wrap_nx  = (wrap_inc == {1'b0, wmod}) ? 9'd0 : wrap_inc[8:0];

  assign tx = 10'd768 - {1'b0, fx_r, 1'b0};
  assign tz = 10'd768 - {1'b0, fz_r, 1'b0};

  assign dpix = $signed({1'b0, mem_rdata}) - $signed({1'b0, cfg.pixel_min});
  assign pval = dpix * $signed({1'b0, cfg.height_scale});
  assign nval = {p_r[25], p_r, 9'b0} + {28'b0, rng8};
  assign nabs = nval[35] ? (~nval + 36'd1) : nval;
  assign hpix = nval[35]
    ? -$signed(div_rsp.quo + DIV_W'(div_rsp.rem != 9'd0))
    : $signed(div_rsp.quo);

  always_comb begin
    case (bsel_r)
      2'd0: begin
        diff = 35'(h_r[1]) - 35'(h_r[0]);
        base = h_r[0];
        wt   = sx_r;
      end
      2'd1: begin
        diff = 35'(h_r[3]) - 35'(h_r[2]);
        base = h_r[2];
        wt   = sx_r;
      end
      default: begin
        diff = 35'(b_r) - 35'(a_r);
        base = a_r;
        wt   = sz_r;
      end
    endcase
  end

  assign mop  = (state_r == S_ML) ? $signed({1'b0, diff[17:0]})
                                  : $signed({{2{diff[34]}}, diff[34:18]});
  assign prod = mop * $signed({1'b0, wt});
  assign full = $signed({phi_r, 18'b0}) + 62'(plo_r);
  assign rnd  = (full + 62'sd8388608) >>> 24;
  assign val  = base + rnd[HW-1:0];

  assign lim  = col_limit(cfg.column_height);
  assign hmax = $signed({10'b0, lim, 16'b0});
  assign hc   = hf_r[HW-1] ? 24'd0 : ((hf_r > hmax) ? hmax[23:0] : hf_r[23:0]);
  assign hq   = 16'(({1'b0, hc} + 25'd128) >> 8);
  assign ys   = 26'($signed({y_r, 8'b0}));
  assign hy   = $signed({10'b0, hq});

  always_comb begin
    if (ys > hy) begin
      kind = KIND_AIR;
    end else if (ys > hy - 26'sd256) begin
      kind = KIND_GRASS;
    end else if (ys > hy - 26'sd1280) begin
      kind = KIND_DIRT;
    end else begin
      kind = KIND_STONE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = no_map ? S_FIN : S_SM1;
        end
      end
      S_SM1:  state_nxt = S_SM2;
      S_SM2:  state_nxt = S_WX;
      S_WX:   state_nxt = S_WXW;
      S_WXW: begin
        if (div_rsp.done) begin
          state_nxt = S_WZ;
        end
      end
      S_WZ:   state_nxt = S_WZW;
      S_WZW: begin
        if (div_rsp.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_PIX;
      S_PIX: begin
        if (rng_ok) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = (k_r == 2'd3) ? S_ML : S_RD;
        end
      end
      S_DIV:  state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_nxt = (k_r == 2'd3) ? S_ML : S_RD;
        end
      end
      S_ML:   state_nxt = S_MH;
      S_MH:   state_nxt = S_MS;
      S_MS:   state_nxt = (bsel_r == 2'd2) ? S_FIN : S_ML;
      S_FIN:  state_nxt = S_OUT;
      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_col    = k_r[0] ? x1_r : x0_r;
    rd_row    = k_r[1] ? z1_r : z0_r;
    idle      = state_r == S_IDLE;
    res_valid = state_r == S_OUT;
    mem_re    = state_r == S_RD;
    mem_raddr = ADDR_W'(rd_row) * ADDR_W'(MAP_COLS_MAX) + ADDR_W'(rd_col);
    div_req   = '0;
    case (state_r)
      S_WX: begin
        div_req.start = 1'b1;
        div_req.num   = {xabs, 18'b0};
        div_req.den   = w_eff;
        div_req.steps = WRAP_STEPS;
      end
      S_WZ: begin
        div_req.start = 1'b1;
        div_req.num   = {zabs, 18'b0};
        div_req.den   = d_eff;
        div_req.steps = WRAP_STEPS;
      end
      S_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = nabs[DIV_W-1:0];
        div_req.den   = {rng8, 1'b0};
        div_req.steps = NORM_STEPS;
      end
      S_WXW, S_WZW, S_DIVW: begin
        div_req.den = (state_r == S_DIVW) ? {rng8, 1'b0}
                    : ((state_r == S_WXW) ? w_eff : d_eff);
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          xi_r   <= sample_x[23:8];
          fx_r   <= sample_x[7:0];
          zi_r   <= sample_z[23:8];
          fz_r   <= sample_z[7:0];
          y_r    <= sample_y;
          k_r    <= 2'd0;
          bsel_r <= 2'd0;
          hf_r   <= '0;
        end
      end
      S_SM1: begin
        sqx_r <= fx_r * fx_r;
        sqz_r <= fz_r * fz_r;
      end
      S_SM2: begin
        sx_r <= 24'(sqx_r * tx);
        sz_r <= 24'(sqz_r * tz);
      end
      S_WXW: begin
        if (div_rsp.done) begin
          x0_r <= wrap;
          x1_r <= wrap_nx;
        end
      end
      S_WZW: begin
        if (div_rsp.done) begin
          z0_r <= wrap;
          z1_r <= wrap_nx;
        end
      end
      S_PIX: begin
        p_r <= pval;
        if (!rng_ok) begin
          h_r[k_r] <= '0;
          k_r      <= k_r + 2'd1;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          h_r[k_r] <= hpix;
          k_r      <= k_r + 2'd1;
        end
      end
      S_ML: plo_r <= prod;
      S_MH: phi_r <= prod;
      S_MS: begin
        case (bsel_r)
          2'd0:    a_r  <= val;
          2'd1:    b_r  <= val;
          default: hf_r <= val;
        endcase
        bsel_r <= bsel_r + 2'd1;
      end
      S_FIN: begin
        res_r.block_kind     <= kind;
        res_r.surface_height <= hq;
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule

### sv/heightmap_terrain_voxel_classifier_top.sv
// Top level: handshakes, configuration registers, pixel store, divider,
// sample sequencer and output register. Depends on hvc_pkg, hvc_pixel_mem,
// hvc_divider and hvc_sampler.
// A write item goes straight to the pixel store. A sample item runs two
// 16-step wraps and four 34-step normalisations in the bit-serial
// divider, four pixel reads and a three-pass blend on the way to the
// output register; an empty pixel range skips the normalisations and no
// map skips all of these. The next item is taken once the sequencer is
// idle; a result waiting in the output register does not block it. Reset
// is synchronous, active low; the pixel store is not cleared.
`timescale 1ns / 1ps

module heightmap_terrain_voxel_classifier_top import hvc_pkg::*; #(
  parameter int MAP_COLS_MAX = 256,
  parameter int MAP_ROWS_MAX = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [23:0] in_sample_x,
  input  logic signed [23:0] in_sample_z,
  input  logic signed [15:0] in_sample_y,
  input  logic [7:0]         in_pixel_col,
  input  logic [7:0]         in_pixel_row,
  input  logic [7:0]         in_pixel_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_block_kind,
  output logic [15:0]        out_surface_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int ADDR_W = $clog2(MAP_COLS_MAX * MAP_ROWS_MAX);
  localparam logic [12:0] COLS_L = 13'(MAP_COLS_MAX);
  localparam logic [12:0] ROWS_L = 13'(MAP_ROWS_MAX);

  cfg_t     cfg_r;
  logic     out_valid_r;
  res_t     out_res_r;
  logic     smp_idle, res_valid, res_take;
  res_t     smp_res;
  logic     in_acc, mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic     mem_re;
  logic [7:0] mem_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = smp_idle;
  assign in_acc    = in_valid && in_ready;
  assign mem_we    = in_acc && (in_func == FUNC_WRITE)
                     && ({5'b0, in_pixel_col} < COLS_L)
                     && ({5'b0, in_pixel_row} < ROWS_L);
  assign mem_waddr = ADDR_W'(in_pixel_row) * ADDR_W'(MAP_COLS_MAX)
                     + ADDR_W'(in_pixel_col);
  assign res_take  = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH:     cfg_r.map_width     <= cfg_data[8:0];
        CFG_MAP_DEPTH:     cfg_r.map_depth     <= cfg_data[8:0];
        CFG_PIXEL_MIN:     cfg_r.pixel_min     <= cfg_data[7:0];
        CFG_PIXEL_MAX:     cfg_r.pixel_max     <= cfg_data[7:0];
        CFG_HEIGHT_SCALE:  cfg_r.height_scale  <= cfg_data;
        CFG_COLUMN_HEIGHT: cfg_r.column_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= smp_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_block_kind     = out_res_r.block_kind;
  assign out_surface_height = out_res_r.surface_height;

  hvc_pixel_mem #(
    .MAP_COLS_MAX(MAP_COLS_MAX),
    .MAP_ROWS_MAX(MAP_ROWS_MAX)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_pixel_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hvc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hvc_sampler #(
    .MAP_COLS_MAX(MAP_COLS_MAX),
    .MAP_ROWS_MAX(MAP_ROWS_MAX)
  ) u_smp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_acc && (in_func == FUNC_SAMPLE)),
    .sample_x  (in_sample_x),
    .sample_z  (in_sample_z),
    .sample_y  (in_sample_y),
    .idle      (smp_idle),
    .res_valid (res_valid),
    .res       (smp_res),
    .res_take  (res_take),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_SAMPLE) |=> !in_ready)
    else $error("sequencer took a new item while a sample was in progress");

  a_height_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_surface_height <= {col_limit(cfg_r.column_height), 8'h00}))
    else $error("surface height above the column limit");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("pixel write collided with a sequencer read");

endmodule

### dv/hvc_checker.sv
// Checker for the heightmap terrain voxel classifier: watches the input,
// result and register channels, predicts each voxel result and compares.
// Depends on hvc_pkg for the register codes and the result struct.
`timescale 1ns / 1ps

module hvc_checker import hvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic signed [23:0] in_sample_x,
  input  logic signed [23:0] in_sample_z,
  input  logic signed [15:0] in_sample_y,
  input  logic [7:0]         in_pixel_col,
  input  logic [7:0]         in_pixel_row,
  input  logic [7:0]         in_pixel_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_block_kind,
  input  logic [15:0]        out_surface_height,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 err_count,
  output int                 voxels_pending
);

  localparam longint ONE_Q24 = 64'sd1 << 24;

  logic [7:0]  heightmap [65536];
  logic [8:0]  map_w, map_d, col_h;
  logic [7:0]  pix_lo, pix_hi;
  logic [15:0] h_scale;
  res_t        voxel_q [$];

  function automatic longint floor_quot(longint n, longint den);
    if (n >= 0) return n / den;
    return -((-n + den - 1) / den);
  endfunction

  function automatic longint round_q24(longint v);
    return floor_quot(v + (64'sd1 <<< 23), ONE_Q24);
  endfunction

  function automatic longint pixel_level(int col, int row);
    longint rng, d;
    rng = longint'(pix_hi) - longint'(pix_lo);
    if (rng <= 0) return 0;
    d = longint'(heightmap[row * 256 + col]) - longint'(pix_lo);
    return floor_quot(2 * d * longint'(h_scale) * 256 + rng, 2 * rng);
  endfunction

  function automatic longint ease(longint f);
    return f * f * (768 - 2 * f);
  endfunction

  function automatic logic [15:0] terrain_height(longint x, longint z);
    longint w, dp, c, u, v, sx, sz, a, b, h;
    int x0, x1, z0, z1;
    w  = (map_w > 256) ? 256 : map_w;
    dp = (map_d > 256) ? 256 : map_d;
    c  = (col_h == 0) ? 1 : ((col_h > 256) ? 256 : col_h);
    if (w == 0 || dp == 0) return 16'd0;
    u = x % (w * 256);
    if (u < 0) u += w * 256;
    v = z % (dp * 256);
    if (v < 0) v += dp * 256;
    x0 = int'(u >> 8);
    z0 = int'(v >> 8);
    x1 = int'((x0 + 1) % w);
    z1 = int'((z0 + 1) % dp);
    sx = ease(u & 255);
    sz = ease(v & 255);
    a = round_q24(pixel_level(x0, z0) * (ONE_Q24 - sx) + pixel_level(x1, z0) * sx);
    b = round_q24(pixel_level(x0, z1) * (ONE_Q24 - sx) + pixel_level(x1, z1) * sx);
    h = round_q24(a * (ONE_Q24 - sz) + b * sz);
    if (h < 0) h = 0;
    if (h > ((c - 1) << 16)) h = (c - 1) << 16;
    return 16'((h + 128) >> 8);
  endfunction

  function automatic res_t classify_voxel(logic signed [23:0] x, logic signed [23:0] z,
                                          logic signed [15:0] y);
    res_t   r;
    longint hy, ys;
    r.surface_height = terrain_height(longint'(x), longint'(z));
    hy = longint'(r.surface_height);
    ys = longint'(y) * 256;
    if (ys > hy) r.block_kind = KIND_AIR;
    else if (ys > hy - 256) r.block_kind = KIND_GRASS;
    else if (ys > hy - 1280) r.block_kind = KIND_DIRT;
    else r.block_kind = KIND_STONE;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      map_w <= 9'd0;
      map_d <= 9'd0;
      pix_lo <= 8'd0;
      pix_hi <= 8'd255;
      h_scale <= 16'd16384;
      col_h <= 9'd96;
      err_count <= 0;
      voxels_pending <= 0;
      voxel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAP_WIDTH:     map_w <= cfg_data[8:0];
          CFG_MAP_DEPTH:     map_d <= cfg_data[8:0];
          CFG_PIXEL_MIN:     pix_lo <= cfg_data[7:0];
          CFG_PIXEL_MAX:     pix_hi <= cfg_data[7:0];
          CFG_HEIGHT_SCALE:  h_scale <= cfg_data;
          CFG_COLUMN_HEIGHT: col_h <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (voxel_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d height %0d", $time,
                   out_block_kind, out_surface_height);
          err_count <= err_count + 1;
        end else begin
          want = voxel_q.pop_front();
          if (want.block_kind !== out_block_kind ||
              want.surface_height !== out_surface_height) begin
            $display("%0t: expected kind %0d height %0d, got kind %0d height %0d",
                     $time, want.block_kind, want.surface_height,
                     out_block_kind, out_surface_height);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WRITE)
          heightmap[{in_pixel_row, in_pixel_col}] = in_pixel_value;
        else
          voxel_q.push_back(classify_voxel(in_sample_x, in_sample_z, in_sample_y));
      end
      voxels_pending <= voxel_q.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the classifier testbench: clock, reset, register phases, pixel
// loading and voxel sampling with random idling. Depends on hvc_pkg,
// hvc_checker and heightmap_terrain_voxel_classifier_top.
`timescale 1ns / 1ps

module testbench;
  import hvc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid, in_ready, in_func;
  logic signed [23:0] in_sample_x, in_sample_z;
  logic signed [15:0] in_sample_y;
  logic [7:0]         in_pixel_col, in_pixel_row, in_pixel_value;
  logic               out_valid, out_ready;
  logic [1:0]         out_block_kind;
  logic [15:0]        out_surface_height;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 err_count, voxels_pending, stall_cycles;
  logic               quiet;

  heightmap_terrain_voxel_classifier_top i_dut (.*);

  hvc_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_item(logic func, logic signed [23:0] x, logic signed [23:0] z,
                           logic signed [15:0] y, logic [7:0] col, logic [7:0] row,
                           logic [7:0] val);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_sample_x <= x;
    in_sample_z <= z;
    in_sample_y <= y;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_pixel_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (voxels_pending != 0 || !in_ready);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(int w, int d, int lo, int hi, int sc, int ch);
    logic [15:0] vals [6];
    vals = '{16'(w), 16'(d), 16'(lo), 16'(hi), 16'(sc), 16'(ch)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_voxel;
    logic signed [23:0] x, z;
    logic signed [15:0] y;
    x = $urandom_range(1) ? 24'($urandom) : 24'(int'($urandom_range(0, 20000)) - 10000);
    z = $urandom_range(1) ? 24'($urandom) : 24'(int'($urandom_range(0, 20000)) - 10000);
    y = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 270)) - 10);
    send_item(FUNC_SAMPLE, x, z, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_WRITE;
    in_sample_x = '0;
    in_sample_z = '0;
    in_sample_y = '0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    in_pixel_value = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAP_WIDTH;
    cfg_data = '0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_SAMPLE, 24'sd0, 24'sd0, 16'sd0, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, -24'sd8388608, 24'sd8388607, -16'sd1, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, 24'sd1234, -24'sd99, 16'sd1, 8'd0, 8'd0, 8'd0);

    for (int r = 0; r < 256; r++)
      for (int c = 0; c < 256; c++)
        send_item(FUNC_WRITE, 24'($urandom), 24'($urandom), 16'($urandom),
                  8'(c), 8'(r), 8'($urandom));
    drain();

    write_regs(4, 3, 10, 200, 4096, 96);
    send_item(FUNC_WRITE, 24'sd0, 24'sd0, 16'sd0, 8'd0, 8'd0, 8'd255);
    send_item(FUNC_WRITE, 24'sd0, 24'sd0, 16'sd0, 8'd1, 8'd0, 8'd0);
    send_item(FUNC_WRITE, 24'sd0, 24'sd0, 16'sd0, 8'd255, 8'd255, 8'd128);
    send_item(FUNC_SAMPLE, 24'sd0, 24'sd0, 16'sd20, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, 24'sd128, 24'sd0, 16'sd0, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, -24'sd1, -24'sd1, 16'sd4, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, -24'sd8388608, -24'sd8388608, -16'sd32768, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, 24'sd8388607, 24'sd8388607, 16'sd32767, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, 24'sd1023, 24'sd767, 16'sd10, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SAMPLE, 24'sd255, 24'sd256, 16'sd12, 8'd0, 8'd0, 8'd0);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: write_regs(256, 256, 0, 255, 65535, 256);
        1: write_regs(511, 300, 50, 120, 300, 0);
        2: write_regs(1, 1, 0, 255, 0, 511);
        3: write_regs(0, 7, 0, 255, 16384, 96);
        4: write_regs(9, 0, 0, 255, 16384, 96);
        5: write_regs(5, 6, 200, 200, 16384, 96);
        6: write_regs(2, 2, 255, 0, 8000, 20);
        7: write_regs(256, 256, 0, 255, 16384, 1);
        default: write_regs($urandom_range(1, 300), $urandom_range(1, 300),
                             $urandom_range(0, 100), $urandom_range(80, 255),
                             $urandom_range(0, 65535), $urandom_range(0, 300));
      endcase
      quiet = (ph == 4 || ph == 5);
      for (int k = 0; k < 100; k++) begin
        if (ph == 2 && k == 50) drain();
        if ($urandom_range(99) < 25)
          send_item(FUNC_WRITE, 24'($urandom), 24'($urandom), 16'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
        else
          random_voxel();
      end
    end
    quiet = 1'b0;

    drain();
    repeat (250) @(posedge clk);
    if (err_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

### filelist.f
sv/hvc_pkg.sv
sv/hvc_pixel_mem.sv
sv/hvc_divider.sv
sv/hvc_sampler.sv
sv/heightmap_terrain_voxel_classifier_top.sv
dv/hvc_checker.sv
dv/testbench.sv
